### rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Each expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("property violated");

// Next-cycle implication.
`define NBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("property violated");

`endif

### rtl/nbt_pkg.sv
`default_nettype none

package nbt_pkg;

    localparam int OP_W    = 1;
    localparam int LEN_W   = 6;
    localparam int KIND_W  = 2;
    localparam int ID_W    = 16;
    localparam int HOP_W   = 8;
    localparam int COUNT_W = 9;
    localparam int BYTE_W  = 8;
    localparam int WIN_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_PACKET = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_BEACON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POKE   = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNASSIGNED_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RX_BLOCKED    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PKT,
        ST_TICK,
        ST_TICK_END,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/nbt_in_if.sv
`default_nettype none

interface nbt_in_if import nbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  frame_len;
    logic              crc_ok;
    logic [KIND_W-1:0] msg_kind;
    logic [ID_W-1:0]   sender_id;
    logic [HOP_W-1:0]  hop_count;

    modport source (
        output valid, op, frame_len, crc_ok, msg_kind, sender_id, hop_count,
        input  ready
    );

    modport sink (
        input  valid, op, frame_len, crc_ok, msg_kind, sender_id, hop_count,
        output ready
    );
endinterface

`default_nettype wire

### rtl/nbt_out_if.sv
`default_nettype none

interface nbt_out_if import nbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] in_range_count;
    logic               newly_seen;
    logic [BYTE_W-1:0]  seen_id;
    logic               flash;
    logic               relay_send;
    logic [BYTE_W-1:0]  relay_id;
    logic [HOP_W-1:0]   relay_hops;
    logic               beacon_send;

    modport source (
        output valid, in_range_count, newly_seen, seen_id, flash, relay_send,
               relay_id, relay_hops, beacon_send,
        input  ready
    );

    modport sink (
        input  valid, in_range_count, newly_seen, seen_id, flash, relay_send,
               relay_id, relay_hops, beacon_send,
        output ready
    );
endinterface

`default_nettype wire

### rtl/neighbor_presence_tracker_core.sv
// Neighbor presence table with aging.
// Channel item (valid/ready): one received packet or one interval tick per transfer.
// Channel result (valid/ready): exactly one result per item, in item order.
// Configuration: cfg_we/cfg_index/cfg_data write own id, unassigned id, window
// and the reception block flag; write only while the block is idle.
// Countdowns live in one single-port-read, single-port-write table of
// NUM_NODES bytes with a registered read.
// A packet that touches the table goes through ST_PKT and ST_DONE before its
// result is registered, any other packet through ST_DONE only. A tick sweeps
// the whole table with a read/write-back pipeline in ST_TICK and ST_TICK_END,
// then goes through ST_DONE.
// Only one item is in work at a time; item ready is high only when idle, and
// the next item may be taken while the previous result still waits.
// After reset the table is cleared one entry per cycle;
// item ready stays low during that pass, configuration writes are taken.
// When the receiver stalls, the result is held and a finished item waits in
// the done state until the output register is free.
`default_nettype none

module neighbor_presence_tracker_core import nbt_pkg::*; #(
    parameter int NUM_NODES    = 256,
    parameter int PACKET_BYTES = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    nbt_in_if.sink                     item,
    nbt_out_if.source                  result
);

    localparam int AW = $clog2(NUM_NODES);
    localparam int TW = $clog2(NUM_NODES + 1);
    localparam int CW = (TW > COUNT_W) ? TW : COUNT_W;
    localparam logic [AW-1:0]    LAST_IDX   = AW'(NUM_NODES - 1);
    localparam logic [ID_W-1:0]  NODE_LIMIT = ID_W'(NUM_NODES);
    localparam logic [LEN_W-1:0] PKT_LEN    = LEN_W'(PACKET_BYTES);
    localparam logic [CW-1:0]    COUNT_MAX  = CW'((1 << COUNT_W) - 1);

    // configuration
    logic [ID_W-1:0]  own_id_reg;
    logic [ID_W-1:0]  unassigned_id_reg;
    logic [WIN_W-1:0] window_reg;
    logic             blocked_reg;

    // table
    logic [WIN_W-1:0] table_mem [NUM_NODES];
    logic [WIN_W-1:0] rdata_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [AW-1:0]    mem_ra;
    logic [WIN_W-1:0] mem_wd;

    // control
    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          wb_valid_reg, wb_valid_next;
    logic [AW-1:0] wb_addr_reg, wb_addr_next;
    logic [TW-1:0] total_reg, total_next;

    // result under construction
    logic [BYTE_W-1:0] id_lo_reg, id_lo_next;
    logic              res_newly_reg, res_newly_next;
    logic [BYTE_W-1:0] res_seen_reg, res_seen_next;
    logic              res_flash_reg, res_flash_next;
    logic              res_relay_reg, res_relay_next;
    logic [BYTE_W-1:0] res_relay_id_reg, res_relay_id_next;
    logic [HOP_W-1:0]  res_hops_reg, res_hops_next;
    logic              res_beacon_reg, res_beacon_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_newly_reg, out_newly_next;
    logic [BYTE_W-1:0]  out_seen_reg, out_seen_next;
    logic               out_flash_reg, out_flash_next;
    logic               out_relay_reg, out_relay_next;
    logic [BYTE_W-1:0]  out_relay_id_reg, out_relay_id_next;
    logic [HOP_W-1:0]   out_hops_reg, out_hops_next;
    logic               out_beacon_reg, out_beacon_next;

    // packet decode
    logic             pk_ok;
    logic             pk_use;
    logic             pk_foreign;
    logic             pk_flash;
    logic             pk_relay;
    logic             pk_table;
    logic [WIN_W-1:0] window_eff;
    logic [CW-1:0]    total_ext;
    logic [COUNT_W-1:0] count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg        <= 16'hFFFF;
            unassigned_id_reg <= 16'hFFFF;
            window_reg        <= 8'd8;
            blocked_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ID:        own_id_reg        <= cfg_data[ID_W-1:0];
                REG_UNASSIGNED_ID: unassigned_id_reg <= cfg_data[ID_W-1:0];
                REG_WINDOW_TICKS:  window_reg        <= cfg_data[WIN_W-1:0];
                REG_RX_BLOCKED:    blocked_reg       <= cfg_data[0];
                default:           blocked_reg       <= blocked_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= table_mem[mem_ra];
    end

    assign window_eff = (window_reg == '0) ? WIN_W'(1) : window_reg;

    assign pk_ok = (item.frame_len == PKT_LEN) && item.crc_ok &&
                   ((item.sender_id < NODE_LIMIT) ||
                    (item.sender_id == unassigned_id_reg));
    assign pk_use     = (item.op == OP_PACKET) && pk_ok && !blocked_reg;
    assign pk_foreign = (item.sender_id != own_id_reg);
    assign pk_flash   = pk_use && (item.msg_kind == KIND_POKE) && pk_foreign;
    assign pk_relay   = pk_flash && (item.hop_count != '0);
    assign pk_table   = pk_use && pk_foreign &&
                        ((item.msg_kind == KIND_POKE) || (item.msg_kind == KIND_BEACON)) &&
                        (item.sender_id != unassigned_id_reg) &&
                        (item.sender_id < NODE_LIMIT);

    assign total_ext = CW'(total_reg);
    assign count_sat = (total_ext > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                               : total_ext[COUNT_W-1:0];

    assign item.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        wb_valid_next     = wb_valid_reg;
        wb_addr_next      = wb_addr_reg;
        total_next        = total_reg;
        id_lo_next        = id_lo_reg;
        res_newly_next    = res_newly_reg;
        res_seen_next     = res_seen_reg;
        res_flash_next    = res_flash_reg;
        res_relay_next    = res_relay_reg;
        res_relay_id_next = res_relay_id_reg;
        res_hops_next     = res_hops_reg;
        res_beacon_next   = res_beacon_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_count_next    = out_count_reg;
        out_newly_next    = out_newly_reg;
        out_seen_next     = out_seen_reg;
        out_flash_next    = out_flash_reg;
        out_relay_next    = out_relay_reg;
        out_relay_id_next = out_relay_id_reg;
        out_hops_next     = out_hops_reg;
        out_beacon_next   = out_beacon_reg;
        mem_we            = 1'b0;
        mem_wa            = wb_addr_reg;
        mem_wd            = '0;
        mem_ra            = cnt_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = cnt_reg;
                mem_wd   = '0;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                mem_ra = item.sender_id[AW-1:0];
                if (item.valid)
                begin
                    id_lo_next        = item.sender_id[BYTE_W-1:0];
                    wb_addr_next      = item.sender_id[AW-1:0];
                    res_newly_next    = 1'b0;
                    res_seen_next     = '0;
                    res_flash_next    = pk_flash;
                    res_relay_next    = pk_relay;
                    res_relay_id_next = pk_relay ? item.sender_id[BYTE_W-1:0] : '0;
                    res_hops_next     = pk_relay ? (item.hop_count - HOP_W'(1)) : '0;
                    res_beacon_next   = (item.op == OP_TICK);
                    if (item.op == OP_TICK)
                    begin
                        cnt_next      = '0;
                        wb_valid_next = 1'b0;
                        state_next    = ST_TICK;
                    end
                    else if (pk_table)
                    begin
                        state_next = ST_PKT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_PKT:
            begin
                mem_we = 1'b1;
                mem_wa = wb_addr_reg;
                mem_wd = window_eff;
                if (rdata_reg == '0)
                begin
                    total_next     = total_reg + TW'(1);
                    res_newly_next = 1'b1;
                    res_seen_next  = id_lo_reg;
                end
                state_next = ST_DONE;
            end

            ST_TICK, ST_TICK_END:
            begin
                // write back the entry read in the previous cycle
                if (wb_valid_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = wb_addr_reg;
                    mem_wd = (rdata_reg != '0) ? (rdata_reg - WIN_W'(1)) : '0;
                    if ((rdata_reg == WIN_W'(1)) && (total_reg != '0))
                    begin
                        total_next = total_reg - TW'(1);
                    end
                end
                if (state_reg == ST_TICK)
                begin
                    mem_ra        = cnt_reg;
                    wb_addr_next  = cnt_reg;
                    wb_valid_next = 1'b1;
                    cnt_next      = cnt_reg + AW'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = ST_TICK_END;
                    end
                end
                else
                begin
                    wb_valid_next = 1'b0;
                    state_next    = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_count_next    = count_sat;
                    out_newly_next    = res_newly_reg;
                    out_seen_next     = res_seen_reg;
                    out_flash_next    = res_flash_reg;
                    out_relay_next    = res_relay_reg;
                    out_relay_id_next = res_relay_id_reg;
                    out_hops_next     = res_hops_reg;
                    out_beacon_next   = res_beacon_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            wb_addr_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wb_valid_reg  <= wb_valid_next;
            wb_addr_reg   <= wb_addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_lo_reg        <= id_lo_next;
        res_newly_reg    <= res_newly_next;
        res_seen_reg     <= res_seen_next;
        res_flash_reg    <= res_flash_next;
        res_relay_reg    <= res_relay_next;
        res_relay_id_reg <= res_relay_id_next;
        res_hops_reg     <= res_hops_next;
        res_beacon_reg   <= res_beacon_next;
        out_count_reg    <= out_count_next;
        out_newly_reg    <= out_newly_next;
        out_seen_reg     <= out_seen_next;
        out_flash_reg    <= out_flash_next;
        out_relay_reg    <= out_relay_next;
        out_relay_id_reg <= out_relay_id_next;
        out_hops_reg     <= out_hops_next;
        out_beacon_reg   <= out_beacon_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.in_range_count = out_count_reg;
    assign result.newly_seen     = out_newly_reg;
    assign result.seen_id        = out_seen_reg;
    assign result.flash          = out_flash_reg;
    assign result.relay_send     = out_relay_reg;
    assign result.relay_id       = out_relay_id_reg;
    assign result.relay_hops     = out_hops_reg;
    assign result.beacon_send    = out_beacon_reg;

endmodule

`default_nettype wire

### rtl/nbt_checker.sv
`default_nettype none
`include "assert_macros.svh"

module nbt_checker import nbt_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COUNT_W-1:0] in_range_count,
    input wire logic               newly_seen,
    input wire logic [BYTE_W-1:0]  seen_id,
    input wire logic               flash,
    input wire logic               relay_send,
    input wire logic [BYTE_W-1:0]  relay_id,
    input wire logic [HOP_W-1:0]   relay_hops,
    input wire logic               beacon_send
);

    logic stalled;
    logic idle_zero;
    logic [COUNT_W+2*BYTE_W+HOP_W+4-1:0] payload;

    assign stalled   = out_valid && !out_ready;
    assign idle_zero = (relay_id == '0) && (relay_hops == '0) && (seen_id == '0);
    assign payload   = {in_range_count, newly_seen, seen_id, flash, relay_send,
                        relay_id, relay_hops, beacon_send};

    // stalled result holds
    `NBT_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(payload))

    // a tick result carries no packet flags
    `NBT_ASSERT_IMP(a_tick_alone, out_valid && beacon_send, !flash && !newly_seen && !relay_send)

    `NBT_ASSERT_IMP(a_relay_flash, out_valid && relay_send, flash)

    // id and hop fields stay zero unless their flag is set
    `NBT_ASSERT_IMP(a_idle_fields, out_valid && !relay_send && !newly_seen, idle_zero)

endmodule

bind neighbor_presence_tracker_core nbt_checker u_nbt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .in_range_count (result.in_range_count),
    .newly_seen     (result.newly_seen),
    .seen_id        (result.seen_id),
    .flash          (result.flash),
    .relay_send     (result.relay_send),
    .relay_id       (result.relay_id),
    .relay_hops     (result.relay_hops),
    .beacon_send    (result.beacon_send)
);

`default_nettype wire

### dv/tb_neighbor_presence_tracker_core.sv
`timescale 1ns / 1ps

module tb_neighbor_presence_tracker_core;
    import nbt_pkg::*;

    localparam int NODES       = 256;
    localparam int PKT_BYTES   = 8;
    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 55;

    localparam logic [LEN_W-1:0]  PKT_LEN      = LEN_W'(PKT_BYTES);
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LEN_W-1:0]  frame_len;
        logic              crc_ok;
        logic [KIND_W-1:0] msg_kind;
        logic [ID_W-1:0]   sender_id;
        logic [HOP_W-1:0]  hop_count;
    } rx_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] in_range_count;
        logic               newly_seen;
        logic [BYTE_W-1:0]  seen_id;
        logic               flash;
        logic               relay_send;
        logic [BYTE_W-1:0]  relay_id;
        logic [HOP_W-1:0]   relay_hops;
        logic               beacon_send;
    } presence_t;

    class presence_scoreboard;
        logic [WIN_W-1:0] ttl [NODES];
        int unsigned      live_count;
        logic [ID_W-1:0]  own_id;
        logic [ID_W-1:0]  unassigned_id;
        logic [WIN_W-1:0] window;
        logic             rx_blocked;
        presence_t        expected_reports [$];
        int unsigned      errors;

        function new();
            foreach (ttl[i]) ttl[i] = '0;
            live_count    = 0;
            own_id        = 16'hFFFF;
            unassigned_id = 16'hFFFF;
            window        = 8'd8;
            rx_blocked    = 1'b0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OWN_ID:        own_id        = data[ID_W-1:0];
                REG_UNASSIGNED_ID: unassigned_id = data[ID_W-1:0];
                REG_WINDOW_TICKS:  window        = data[WIN_W-1:0];
                REG_RX_BLOCKED:    rx_blocked    = data[0];
                default: ;
            endcase
        endfunction

        function void mark_seen(logic [ID_W-1:0] id, inout presence_t r);
            if (id == unassigned_id || id == own_id || id >= NODES)
                return;
            if (ttl[id] == 0) begin
                live_count++;
                r.newly_seen = 1'b1;
                r.seen_id    = id[BYTE_W-1:0];
            end
            // a zero window still keeps the neighbor for one tick
            ttl[id] = (window == 0) ? 8'd1 : window;
        endfunction

        function void note_item(rx_item_t it);
            presence_t r;
            bit        usable;
            r = '0;
            if (it.op == OP_TICK) begin
                for (int i = 0; i < NODES; i++) begin
                    if (ttl[i] != 0) begin
                        ttl[i]--;
                        if (ttl[i] == 0 && live_count > 0)
                            live_count--;
                    end
                end
                r.beacon_send = 1'b1;
            end else begin
                usable = (it.frame_len == PKT_LEN) && it.crc_ok &&
                         (it.sender_id < NODES || it.sender_id == unassigned_id);
                if (usable && !rx_blocked) begin
                    if (it.msg_kind == KIND_POKE) begin
                        if (it.sender_id != own_id) begin
                            r.flash = 1'b1;
                            if (it.hop_count != 0) begin
                                r.relay_send = 1'b1;
                                r.relay_id   = it.sender_id[BYTE_W-1:0];
                                r.relay_hops = it.hop_count - 8'd1;
                            end
                            mark_seen(it.sender_id, r);
                        end
                    end else if (it.msg_kind == KIND_BEACON) begin
                        mark_seen(it.sender_id, r);
                    end
                end
            end
            r.in_range_count = (live_count > 511) ? 9'd511 : COUNT_W'(live_count);
            expected_reports.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(presence_t got);
            presence_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            cmp("in_range_count", 16'(want.in_range_count), 16'(got.in_range_count));
            cmp("newly_seen", 16'(want.newly_seen), 16'(got.newly_seen));
            cmp("seen_id", 16'(want.seen_id), 16'(got.seen_id));
            cmp("flash", 16'(want.flash), 16'(got.flash));
            cmp("relay_send", 16'(want.relay_send), 16'(got.relay_send));
            cmp("relay_id", 16'(want.relay_id), 16'(got.relay_id));
            cmp("relay_hops", 16'(want.relay_hops), 16'(got.relay_hops));
            cmp("beacon_send", 16'(want.beacon_send), 16'(got.beacon_send));
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nbt_in_if  item_if ();
    nbt_out_if result_if ();

    neighbor_presence_tracker_core #(
        .NUM_NODES    (NODES),
        .PACKET_BYTES (PKT_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    presence_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    rx_item_t    taken_item;
    presence_t   taken_report;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        result_if.ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk) begin
        if (rst_n && item_if.valid && item_if.ready) begin
            taken_item.op        = item_if.op;
            taken_item.frame_len = item_if.frame_len;
            taken_item.crc_ok    = item_if.crc_ok;
            taken_item.msg_kind  = item_if.msg_kind;
            taken_item.sender_id = item_if.sender_id;
            taken_item.hop_count = item_if.hop_count;
            sb.note_item(taken_item);
        end
        if (rst_n && result_if.valid && result_if.ready) begin
            taken_report.in_range_count = result_if.in_range_count;
            taken_report.newly_seen     = result_if.newly_seen;
            taken_report.seen_id        = result_if.seen_id;
            taken_report.flash          = result_if.flash;
            taken_report.relay_send     = result_if.relay_send;
            taken_report.relay_id       = result_if.relay_id;
            taken_report.relay_hops     = result_if.relay_hops;
            taken_report.beacon_send    = result_if.beacon_send;
            sb.check_report(taken_report);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic rx_item_t mk(logic [OP_W-1:0] op, logic [LEN_W-1:0] len, logic crc,
                                    logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                    logic [HOP_W-1:0] hops);
        rx_item_t it;
        it.op        = op;
        it.frame_len = len;
        it.crc_ok    = crc;
        it.msg_kind  = kind;
        it.sender_id = id;
        it.hop_count = hops;
        return it;
    endfunction

    function automatic rx_item_t random_item();
        rx_item_t    it;
        int unsigned sel;
        it.op        = ($urandom_range(99) < 25) ? OP_TICK : OP_PACKET;
        it.frame_len = PKT_LEN;
        it.crc_ok    = 1'b1;
        sel = $urandom_range(99);
        if (sel < 45)      it.msg_kind = KIND_BEACON;
        else if (sel < 85) it.msg_kind = KIND_POKE;
        else if (sel < 93) it.msg_kind = KIND_SPARE_A;
        else               it.msg_kind = KIND_SPARE_B;
        // mostly a small pool so neighbors are seen again before they age out
        sel = $urandom_range(99);
        if (sel < 45)      it.sender_id = ID_W'($urandom_range(0, 15));
        else if (sel < 75) it.sender_id = ID_W'($urandom_range(0, NODES - 1));
        else if (sel < 83) it.sender_id = sb.own_id;
        else if (sel < 90) it.sender_id = sb.unassigned_id;
        else               it.sender_id = ID_W'($urandom_range(0, 16'hFFFF));
        sel = $urandom_range(99);
        if (sel < 20)      it.hop_count = 8'd0;
        else if (sel < 30) it.hop_count = 8'hFF;
        else               it.hop_count = HOP_W'($urandom_range(0, 255));
        // broken frames
        if ($urandom_range(99) < 15) begin
            it.frame_len = LEN_W'($urandom_range(0, 32));
            it.crc_ok    = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input rx_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid     = 1'b1;
        item_if.op        = it.op;
        item_if.frame_len = it.frame_len;
        item_if.crc_ok    = it.crc_ok;
        item_if.msg_kind  = it.msg_kind;
        item_if.sender_id = it.sender_id;
        item_if.hop_count = it.hop_count;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        item_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [ID_W-1:0] own, input logic [ID_W-1:0] unas,
                             input logic [WIN_W-1:0] win, input logic blk);
        drain();
        write_reg(REG_OWN_ID, own);
        write_reg(REG_UNASSIGNED_ID, unas);
        write_reg(REG_WINDOW_TICKS, CFG_DATA_W'(win));
        write_reg(REG_RX_BLOCKED, CFG_DATA_W'(blk));
    endtask

    initial begin : stimulus
        int       order [NODES];
        int       j;
        int       tmp;
        rx_item_t junk_tick;

        sb = new();
        send_idle_pct       = 10;
        recv_idle_pct       = 80;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        item_if.valid       = 1'b0;
        item_if.op          = OP_PACKET;
        item_if.frame_len   = '0;
        item_if.crc_ok      = 1'b0;
        item_if.msg_kind    = KIND_BEACON;
        item_if.sender_id   = '0;
        item_if.hop_count   = '0;
        junk_tick = mk(OP_TICK, 6'd32, 1'b0, KIND_SPARE_B, 16'hFFFF, 8'hFF);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        configure(16'd5, 16'hFFFF, 8'd3, 1'b0);
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd0, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd255, 8'd7));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd0, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd5, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd256, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'hFFFF, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'd10, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'd20, 8'hFF));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'hFFFF, 8'd1));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'd5, 8'd3));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_SPARE_A, 16'd30, 8'd2));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_SPARE_B, 16'd31, 8'd2));
        send_item(mk(OP_PACKET, 6'd7, 1'b1, KIND_BEACON, 16'd40, 8'd0));
        send_item(mk(OP_PACKET, 6'd0, 1'b1, KIND_BEACON, 16'd41, 8'd0));
        send_item(mk(OP_PACKET, 6'd32, 1'b1, KIND_POKE, 16'd42, 8'd9));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b0, KIND_POKE, 16'd43, 8'd9));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'hFFFE, 8'd0));
        repeat (4) send_item(junk_tick);

        // blocked reception drops everything but ticks
        configure(16'd5, 16'hFFFF, 8'd3, 1'b1);
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd1, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'd2, 8'd4));

        // zero window, unassigned id inside the table range
        configure(16'hFFFF, 16'd0, 8'd0, 1'b0);
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd7, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, 16'd0, 8'd0));
        send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_POKE, 16'd0, 8'd2));
        send_item(junk_tick);

        // fill the whole table in shuffled order, then age it all out
        configure(16'hABCD, 16'h5432, 8'd2, 1'b0);
        for (int i = 0; i < NODES; i++)
            order[i] = i;
        for (int i = NODES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NODES; i++)
            send_item(mk(OP_PACKET, PKT_LEN, 1'b1, KIND_BEACON, ID_W'(order[i]),
                         HOP_W'($urandom_range(0, 255))));
        repeat (3) send_item(junk_tick);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(ID_W'($urandom_range(0, NODES - 1)),
                             ID_W'($urandom_range(0, NODES - 1)), 8'd1, 1'b0);
                1: configure(ID_W'($urandom_range(0, 16'hFFFF)), 16'hFFFF, 8'd255, 1'b0);
                2: configure(ID_W'($urandom_range(0, NODES - 1)),
                             ID_W'($urandom_range(0, 16'hFFFF)),
                             WIN_W'($urandom_range(2, 6)), 1'b0);
                3: configure(ID_W'($urandom_range(0, 16'hFFFF)),
                             ID_W'($urandom_range(0, 16'hFFFF)),
                             WIN_W'($urandom_range(1, 255)), 1'b1);
                4: configure(16'd0, 16'd0, WIN_W'($urandom_range(2, 4)), 1'b0);
                default: configure(ID_W'($urandom_range(0, NODES - 1)), 16'hFFFF,
                                   WIN_W'($urandom_range(1, 8)), 1'b0);
            endcase
            if (phase == 0) begin
                send_idle_pct = 80;
                recv_idle_pct = 10;
            end else if (phase == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ((phase == 3) ? 15 : PHASE_ITEMS); n++)
                send_item(random_item());
        end

        drain();
        repeat (NODES + 8) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/nbt_pkg.sv
rtl/nbt_in_if.sv
rtl/nbt_out_if.sv
rtl/neighbor_presence_tracker_core.sv
rtl/nbt_checker.sv
dv/tb_neighbor_presence_tracker_core.sv
